// ===== sv/upc_pkg.sv =====
`default_nettype none

package upc_pkg;

    localparam int unsigned NUM_RESERVED = 19;
    localparam int unsigned DEFAULT_FIFO_DEPTH = 2;

    localparam logic [7:0] PCT_CHAR = 8'h25;

    localparam logic [7:0] RESERVED_TAB [NUM_RESERVED] = '{
        8'h20, 8'h21, 8'h23, 8'h24, 8'h25, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B,
        8'h2C, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h5B, 8'h40, 8'h5C, 8'h5D
    };

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_PCT  = 2'd1,
        PEND_BYTE = 2'd2
    } pend_t;

    // One queue entry: up to three output bytes of one request, sent from b0 up.
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       last;
    } upc_entry_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'd0, v};
        end else begin
            r = 8'h37 + {4'd0, v};
        end
        return r;
    endfunction

    function automatic logic is_reserved(input logic [7:0] b);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_RESERVED; i++) begin
            if (RESERVED_TAB[i] == b) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Bit 8 flags a match, bits 7:0 hold the decoded byte.
    function automatic logic [8:0] match_code(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] r;
        r = '0;
        for (int i = 0; i < NUM_RESERVED; i++) begin
            if (hex_digit(RESERVED_TAB[i][7:4]) == a && hex_digit(RESERVED_TAB[i][3:0]) == b) begin
                r = {1'b1, RESERVED_TAB[i]};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/upc_front.sv =====
`default_nettype none

module upc_front (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [7:0]          s_tdata,   // data_byte[7:0]
    input  wire                 s_tlast,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire                 cfg_data,
    input  wire                 q_full,
    output logic                q_push,
    output upc_pkg::upc_entry_t q_entry
);
    import upc_pkg::*;

    mode_t      mode_reg, mode_next;
    pend_t      pend_reg, pend_next;
    logic [7:0] held_reg, held_next;
    logic [8:0] match;
    logic       accept;

    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign match     = match_code(held_reg, s_tdata);

    always_comb begin
        q_entry      = '0;
        q_entry.last = s_tlast;
        mode_next    = mode_reg;
        pend_next    = pend_reg;
        held_next    = held_reg;
        if (accept) begin
            if (mode_reg == MODE_ENCODE) begin
                pend_next = PEND_NONE;
                if (is_reserved(s_tdata)) begin
                    q_entry.cnt = 2'd3;
                    q_entry.b0  = PCT_CHAR;
                    q_entry.b1  = hex_digit(s_tdata[7:4]);
                    q_entry.b2  = hex_digit(s_tdata[3:0]);
                end else begin
                    q_entry.cnt = 2'd1;
                    q_entry.b0  = s_tdata;
                end
            end else begin
                unique case (pend_reg)
                    PEND_PCT: begin
                        if (s_tlast) begin
                            pend_next   = PEND_NONE;
                            q_entry.cnt = 2'd2;
                            q_entry.b0  = PCT_CHAR;
                            q_entry.b1  = s_tdata;
                        end else begin
                            pend_next = PEND_BYTE;
                            held_next = s_tdata;
                        end
                    end
                    PEND_BYTE: begin
                        pend_next = PEND_NONE;
                        if (match[8]) begin
                            q_entry.cnt = 2'd1;
                            q_entry.b0  = match[7:0];
                        end else if (held_reg == PCT_CHAR) begin
                            if (s_tlast) begin
                                q_entry.cnt = 2'd3;
                                q_entry.b0  = PCT_CHAR;
                                q_entry.b1  = PCT_CHAR;
                                q_entry.b2  = s_tdata;
                            end else begin
                                q_entry.cnt = 2'd1;
                                q_entry.b0  = PCT_CHAR;
                                pend_next   = PEND_BYTE;
                                held_next   = s_tdata;
                            end
                        end else if (s_tdata == PCT_CHAR && !s_tlast) begin
                            q_entry.cnt = 2'd2;
                            q_entry.b0  = PCT_CHAR;
                            q_entry.b1  = held_reg;
                            pend_next   = PEND_PCT;
                        end else begin
                            q_entry.cnt = 2'd3;
                            q_entry.b0  = PCT_CHAR;
                            q_entry.b1  = held_reg;
                            q_entry.b2  = s_tdata;
                        end
                    end
                    default: begin
                        pend_next = PEND_NONE;
                        if (s_tdata == PCT_CHAR && !s_tlast) begin
                            pend_next = PEND_PCT;
                        end else begin
                            q_entry.cnt = 2'd1;
                            q_entry.b0  = s_tdata;
                        end
                    end
                endcase
            end
        end
        if (cfg_valid && cfg_ready) begin
            mode_next = mode_t'(cfg_data);
            pend_next = PEND_NONE;
        end
        q_push = accept && (q_entry.cnt != 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_ENCODE;
            pend_reg <= PEND_NONE;
        end else begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
    end

endmodule

`default_nettype wire

// ===== sv/upc_fifo.sv =====
`default_nettype none

module upc_fifo #(
    parameter int unsigned DEPTH = upc_pkg::DEFAULT_FIFO_DEPTH
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  upc_pkg::upc_entry_t push_data,
    output logic                full,
    input  wire                 pop,
    output logic                pop_valid,
    output upc_pkg::upc_entry_t pop_data
);
    import upc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    upc_entry_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/upc_back.sv =====
`default_nettype none

module upc_back (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 q_valid,
    input  upc_pkg::upc_entry_t q_entry,
    output logic                q_pop,
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [7:0]          m_tdata,   // out_byte[7:0]
    output logic                m_tlast
);
    import upc_pkg::*;

    upc_entry_t cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [1:0] idx_reg, idx_next;
    logic       final_byte;

    assign final_byte = (idx_reg == cur_reg.cnt - 2'd1);
    assign m_tvalid   = cur_valid_reg;
    assign m_tlast    = cur_reg.last && final_byte;

    always_comb begin
        unique case (idx_reg)
            2'd0:    m_tdata = cur_reg.b0;
            2'd1:    m_tdata = cur_reg.b1;
            default: m_tdata = cur_reg.b2;
        endcase
    end

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        q_pop          = 1'b0;
        if (!cur_valid_reg || (m_tready && final_byte)) begin
            q_pop          = q_valid;
            cur_valid_next = q_valid;
            cur_next       = q_entry;
            idx_next       = 2'd0;
        end else if (m_tready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
    end

endmodule

`default_nettype wire

// ===== sv/url_percent_codec.sv =====
`default_nettype none

// Streaming URL percent encoder and decoder, one byte per request on each side.
// The mode register selects encoding (0) or decoding (1); writing it drops any
// partly received percent code. A request is classified on the cycle it is
// accepted and its output bytes are queued, so input is taken every cycle while
// the queue has room. The output port carries one byte per cycle while m_tready is
// high and bytes are queued, which sets the rate: a reserved byte in encode mode
// gives three output bytes, a byte that passes through gives one, and in decode
// mode a request yields zero to three bytes; one that yields none is still accepted.
module url_percent_codec #(
    parameter int unsigned FIFO_DEPTH = upc_pkg::DEFAULT_FIFO_DEPTH
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // data_byte[7:0]
    input  wire        s_tlast,
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic       m_tlast,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire        cfg_data
);
    import upc_pkg::*;

    upc_entry_t push_entry, pop_entry;
    logic       q_push, q_full, q_pop, q_valid;

    upc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    upc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (pop_entry)
    );

    upc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (pop_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== tb/url_percent_codec_checker.sv =====
`timescale 1ns / 100ps

module url_percent_codec_checker (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    input  wire        s_tready,
    input  wire  [7:0] s_tdata,   // data_byte[7:0]
    input  wire        s_tlast,
    input  wire        m_tvalid,
    input  wire        m_tready,
    input  wire  [7:0] m_tdata,   // out_byte[7:0]
    input  wire        m_tlast,
    input  wire        cfg_valid,
    input  wire        cfg_ready,
    input  wire        cfg_data,
    output int         fail_count,
    output int         waiting
);
    import upc_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_char_t;

    localparam logic [7:0] PERCENT = 8'h25;
    localparam logic [7:0] SPECIALS [19] = '{
        8'h20, 8'h21, 8'h23, 8'h24, 8'h25, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B,
        8'h2C, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h5B, 8'h40, 8'h5C, 8'h5D
    };

    mode_t      cur_mode = MODE_ENCODE;
    pend_t      held_state = PEND_NONE;
    logic [7:0] held_char = 8'h00;
    out_char_t  due_chars[$];
    int         errors = 0;

    assign fail_count = errors;

    function automatic logic [7:0] to_hex(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'd0, v};
        end else begin
            r = 8'h41 + {4'd0, v - 4'd10};
        end
        return r;
    endfunction

    function automatic bit is_special(input logic [7:0] b);
        foreach (SPECIALS[i]) begin
            if (SPECIALS[i] == b) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit decode_pair(input logic [7:0] hi, input logic [7:0] lo,
                                       output logic [7:0] ch);
        ch = 8'h00;
        foreach (SPECIALS[i]) begin
            if (to_hex(SPECIALS[i][7:4]) == hi && to_hex(SPECIALS[i][3:0]) == lo) begin
                ch = SPECIALS[i];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void emit_char(input logic [7:0] d, input logic l);
        out_char_t c;
        c.data = d;
        c.last = l;
        due_chars.push_back(c);
    endfunction

    function automatic void plain_char(input logic [7:0] b, input logic fin);
        if (b == PERCENT) begin
            if (fin) begin
                emit_char(PERCENT, 1'b1);
            end else begin
                held_state = PEND_PCT;
            end
        end else begin
            emit_char(b, fin);
        end
    endfunction

    // A percent sign is held and b is the first byte after it.
    function automatic void after_percent(input logic [7:0] b, input logic fin);
        if (fin) begin
            held_state = PEND_NONE;
            emit_char(PERCENT, 1'b0);
            plain_char(b, 1'b1);
        end else begin
            held_char = b;
            held_state = PEND_BYTE;
        end
    endfunction

    function automatic void decode_char(input logic [7:0] b, input logic fin);
        logic [7:0] h;
        logic [7:0] d;
        unique case (held_state)
            PEND_PCT: begin
                after_percent(b, fin);
            end
            PEND_BYTE: begin
                h = held_char;
                held_state = PEND_NONE;
                if (decode_pair(h, b, d)) begin
                    emit_char(d, fin);
                end else begin
                    emit_char(PERCENT, 1'b0);
                    plain_char(h, 1'b0);
                    if (held_state == PEND_PCT) begin
                        after_percent(b, fin);
                    end else begin
                        plain_char(b, fin);
                    end
                end
            end
            default: begin
                held_state = PEND_NONE;
                plain_char(b, fin);
            end
        endcase
    endfunction

    function automatic void encode_char(input logic [7:0] b, input logic fin);
        held_state = PEND_NONE;
        if (is_special(b)) begin
            emit_char(PERCENT, 1'b0);
            emit_char(to_hex(b[7:4]), 1'b0);
            emit_char(to_hex(b[3:0]), fin);
        end else begin
            emit_char(b, fin);
        end
    endfunction

    always @(posedge aclk) begin
        out_char_t want;
        if (!aresetn) begin
            cur_mode = MODE_ENCODE;
            held_state = PEND_NONE;
            held_char = 8'h00;
            due_chars.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                cur_mode = mode_t'(cfg_data);
                held_state = PEND_NONE;
            end
            if (s_tvalid && s_tready) begin
                if (cur_mode == MODE_DECODE) begin
                    decode_char(s_tdata, s_tlast);
                end else begin
                    encode_char(s_tdata, s_tlast);
                end
            end
            if (m_tvalid && m_tready) begin
                if (due_chars.size() == 0) begin
                    $error("out_byte unexpected: actual %02h", m_tdata);
                    errors++;
                end else begin
                    want = due_chars.pop_front();
                    if (m_tdata !== want.data) begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.data, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("out_last mismatch: expected %0b, actual %0b",
                               want.last, m_tlast);
                        errors++;
                    end
                end
            end
        end
        waiting <= due_chars.size();
    end

endmodule

// ===== tb/url_percent_codec_tb.sv =====
`timescale 1ns / 100ps

module url_percent_codec_tb;
    import upc_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_char_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;

    int       fail_count;
    int       waiting;
    int       cycles = 0;
    int       rx_style = 1;
    bit       hold_request = 1'b0;
    bit       tx_gaps = 1'b1;
    in_char_t stim[$];

    url_percent_codec dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    url_percent_codec_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .waiting    (waiting)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int hold_left;
        int tick;
        logic [15:0] pat;
        hold_left = 0;
        tick = 0;
        pat = 16'hFFFF;
        forever begin
            @(posedge aclk);
            if (tick % 16 == 0) begin
                pat = 16'($urandom);
            end
            tick++;
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                unique case (rx_style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= pat[4'(tick % 16)];
                endcase
            end
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'd0, v};
        end else begin
            r = (lower ? 8'h61 : 8'h41) + {4'd0, v - 4'd10};
        end
        return r;
    endfunction

    function automatic void add_char(input logic [7:0] d, input logic l);
        in_char_t c;
        c.data = d;
        c.last = l;
        stim.push_back(c);
    endfunction

    function automatic void add_code(input logic [7:0] ch, input bit lower);
        add_char(PCT_CHAR, 1'b0);
        add_char(hex_char(ch[7:4], lower), 1'b0);
        add_char(hex_char(ch[3:0], lower), 1'b0);
    endfunction

    // Decode streams are mostly valid codes; the rest are broken codes and noise.
    function automatic void make_chars(input mode_t m, input int count);
        int r;
        logic [7:0] rsv;
        while (stim.size() < count) begin
            r = $urandom_range(0, 9);
            rsv = RESERVED_TAB[$urandom_range(0, NUM_RESERVED - 1)];
            if (m == MODE_DECODE) begin
                if (r <= 4) begin
                    add_code(rsv, 1'b0);
                end else if (r == 5) begin
                    add_code(rsv, 1'b1);
                end else if (r == 6) begin
                    add_char(PCT_CHAR, 1'b0);
                    add_char(8'($urandom_range(0, 255)), 1'b0);
                    add_char(8'($urandom_range(0, 255)), 1'b0);
                end else if (r == 7) begin
                    add_char(PCT_CHAR, 1'b0);
                    add_char(hex_char(rsv[7:4], 1'b0), 1'b0);
                    add_char(8'($urandom_range(0, 255)), 1'b0);
                end else begin
                    add_char(8'($urandom_range(0, 255)), 1'b0);
                end
            end else begin
                if (r <= 3) begin
                    add_char(rsv, 1'b0);
                end else begin
                    add_char(8'($urandom_range(0, 255)), 1'b0);
                end
            end
            if ($urandom_range(0, 4) == 0) begin
                stim[stim.size() - 1].last = 1'b1;
            end
            if ($urandom_range(0, 23) == 0) begin
                stim[$urandom_range(0, stim.size() - 1)].last = 1'b1;
            end
        end
    endfunction

    task automatic send_chars();
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 12);
        foreach (stim[i]) begin
            s_tvalid <= 1'b1;
            s_tdata <= stim[i].data;
            s_tlast <= stim[i].last;
            do @(posedge aclk); while (!(s_tvalid && s_tready));
            burst_left--;
            if (tx_gaps && burst_left == 0) begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                burst_left = $urandom_range(1, 12);
            end
        end
        stim.delete();
    endtask

    // The trailing cycles cover a request still held inside the block.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (waiting != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_mode(input mode_t m);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        mode_t m;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_mode(MODE_ENCODE);
        add_char(8'h00, 1'b0);
        add_char(8'hFF, 1'b0);
        add_char(8'h20, 1'b0);
        add_char(8'h5D, 1'b0);
        add_char(8'h25, 1'b0);
        add_char(8'h61, 1'b1);
        send_chars();

        set_mode(MODE_DECODE);
        add_code(8'h2A, 1'b0);
        stim[stim.size() - 1].last = 1'b1;
        add_code(8'h2A, 1'b1);
        stim[stim.size() - 1].last = 1'b1;
        add_char(8'h25, 1'b0);
        add_char(8'h25, 1'b0);
        add_char(8'h34, 1'b0);
        add_char(8'h31, 1'b1);
        add_char(8'h25, 1'b0);
        add_char(8'h35, 1'b1);
        add_char(8'h25, 1'b1);
        add_char(8'hFF, 1'b0);
        add_char(8'h00, 1'b1);
        add_code(8'h20, 1'b0);
        add_char(8'h25, 1'b0);
        add_char(8'h34, 1'b0);
        send_chars();

        // The mode write drops the held percent sign and digit.
        set_mode(MODE_DECODE);

        for (int p = 0; p < 6; p++) begin
            m = (p % 2 == 1) ? MODE_DECODE : MODE_ENCODE;
            set_mode(m);
            rx_style = p % 3;
            tx_gaps = (p != 3);
            if (p == 1) begin
                hold_request = 1'b1;
            end
            make_chars(m, (p == 4) ? 18 : 30);
            send_chars();
            if (p == 4) begin
                drain();
                make_chars(m, 18);
                send_chars();
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/upc_pkg.sv
sv/upc_front.sv
sv/upc_fifo.sv
sv/upc_back.sv
sv/url_percent_codec.sv
tb/url_percent_codec_checker.sv
tb/url_percent_codec_tb.sv
